@@ sv/sbpm_pkg.sv @@
// shared types and constants for the six-button pad multiplexer
package sbpm_pkg;

  // item kinds
  typedef enum logic {
    OP_POLL = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // which set of lines goes onto the port
  typedef enum logic [1:0] {
    MAP_SEL_LO,
    MAP_SEL_HI,
    MAP_IDENTIFY,
    MAP_EXTRA
  } map_sel_t;

  localparam int unsigned BTN_W   = 12;
  localparam int unsigned PINS_W  = 6;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned CNT_W   = 8;

  typedef logic [BTN_W-1:0]   btn_t;
  typedef logic [PINS_W-1:0]  pins_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam cnt_t   IDLE_TIMEOUT_RESET = 8'd12;
  localparam cnt_t   IDLE_MAX           = 8'hFF;
  localparam phase_t PHASE_LAST         = 3'd7;
  localparam phase_t PHASE_IDENTIFY     = 3'd4;
  localparam phase_t PHASE_EXTRA        = 3'd5;

  // button bit positions
  localparam int unsigned BIT_UP    = 0;
  localparam int unsigned BIT_DOWN  = 1;
  localparam int unsigned BIT_LEFT  = 2;
  localparam int unsigned BIT_RIGHT = 3;
  localparam int unsigned BIT_A     = 4;
  localparam int unsigned BIT_B     = 5;
  localparam int unsigned BIT_C     = 6;
  localparam int unsigned BIT_START = 7;
  localparam int unsigned BIT_X     = 8;
  localparam int unsigned BIT_Y     = 9;
  localparam int unsigned BIT_Z     = 10;
  localparam int unsigned BIT_MODE  = 11;

  // pad state carried between words
  typedef struct packed {
    phase_t phase;
    logic   six_mode;
    logic   last_sel;
    cnt_t   idle_cnt;
  } pad_state_t;

endpackage

@@ sv/sbpm_pin_sel.sv @@
// port line selection from mode, phase, select level and buttons
module sbpm_pin_sel (
  input  logic           six_mode,
  input  sbpm_pkg::phase_t phase,
  input  logic           sel,
  input  sbpm_pkg::btn_t buttons,
  output sbpm_pkg::pins_t pins
);

  sbpm_pkg::map_sel_t map_sel;
  sbpm_pkg::btn_t     rel;

  // lines are active low
  assign rel = ~buttons;

  always_comb begin
    if (!six_mode) begin
      map_sel = sel ? sbpm_pkg::MAP_SEL_HI : sbpm_pkg::MAP_SEL_LO;
    end else begin
      case (phase)
        sbpm_pkg::PHASE_IDENTIFY: map_sel = sbpm_pkg::MAP_IDENTIFY;
        sbpm_pkg::PHASE_EXTRA:    map_sel = sbpm_pkg::MAP_EXTRA;
        default:                  map_sel = phase[0] ? sbpm_pkg::MAP_SEL_HI
                                                     : sbpm_pkg::MAP_SEL_LO;
      endcase
    end
  end

  always_comb begin
    case (map_sel)
      sbpm_pkg::MAP_SEL_HI: begin
        pins = {rel[sbpm_pkg::BIT_C], rel[sbpm_pkg::BIT_B], rel[sbpm_pkg::BIT_RIGHT],
                rel[sbpm_pkg::BIT_LEFT], rel[sbpm_pkg::BIT_DOWN], rel[sbpm_pkg::BIT_UP]};
      end
      sbpm_pkg::MAP_IDENTIFY: begin
        pins = {rel[sbpm_pkg::BIT_START], rel[sbpm_pkg::BIT_A], 4'b0000};
      end
      sbpm_pkg::MAP_EXTRA: begin
        pins = {rel[sbpm_pkg::BIT_C], rel[sbpm_pkg::BIT_B], rel[sbpm_pkg::BIT_MODE],
                rel[sbpm_pkg::BIT_X], rel[sbpm_pkg::BIT_Y], rel[sbpm_pkg::BIT_Z]};
      end
      default: begin
        pins = {rel[sbpm_pkg::BIT_START], rel[sbpm_pkg::BIT_A], 2'b00,
                rel[sbpm_pkg::BIT_DOWN], rel[sbpm_pkg::BIT_UP]};
      end
    endcase
  end

endmodule

@@ sv/six_button_pad_multiplexer.sv @@
// top level of the six-button pad multiplexer
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | operation, select_level, buttons
//   out     | output    | out_valid/out_stall| pins, six_mode, phase_now
//   cfg     | input     | cfg_wr_en          | idle_timeout
//
// one word per cycle while out_stall does not hold the flow; a taken word passes
// through the input register, then the result register, with the state update between them
// reset clears phase, mode, idle count, sets last select high, timeout to 12
// a stalled result holds; one more word still fits in the input register
module six_button_pad_multiplexer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_operation,
  input  logic                   in_select_level,
  input  logic [11:0]            in_buttons,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [5:0]             out_pins,
  output logic                   out_six_mode,
  output logic [2:0]             out_phase_now,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data
);

  logic                 in_valid_r;
  sbpm_pkg::op_t        op_r;
  logic                 sel_r;
  sbpm_pkg::btn_t       btn_r;
  logic                 out_valid_r;
  sbpm_pkg::pins_t      pins_r;
  logic                 six_mode_r;
  sbpm_pkg::phase_t     phase_r;
  sbpm_pkg::cnt_t       timeout_r;
  sbpm_pkg::pad_state_t st_r;
  sbpm_pkg::pad_state_t st_nxt;
  sbpm_pkg::cnt_t       cnt_inc;
  sbpm_pkg::pins_t      pins_nxt;
  logic                 advance;
  logic                 in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= sbpm_pkg::op_t'(in_operation);
      sel_r <= in_select_level;
      btn_r <= in_buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sbpm_pkg::IDLE_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // saturating idle count
  assign cnt_inc = (st_r.idle_cnt == sbpm_pkg::IDLE_MAX) ? sbpm_pkg::IDLE_MAX
                                                         : st_r.idle_cnt + 8'd1;

  always_comb begin
    st_nxt = st_r;
    case (op_r)
      sbpm_pkg::OP_POLL: begin
        if (sel_r != st_r.last_sel) begin
          st_nxt.last_sel = sel_r;
          st_nxt.idle_cnt = '0;
          st_nxt.phase    = st_r.phase + 3'd1;
          if (st_r.phase == sbpm_pkg::PHASE_LAST) begin
            st_nxt.six_mode = 1'b1;
          end
        end
      end
      sbpm_pkg::OP_TICK: begin
        st_nxt.idle_cnt = cnt_inc;
        if (cnt_inc > timeout_r) begin
          st_nxt.phase    = '0;
          st_nxt.six_mode = 1'b0;
        end
      end
      default: st_nxt = st_r;
    endcase
  end

  sbpm_pin_sel u_pin_sel (
    .six_mode (st_nxt.six_mode),
    .phase    (st_nxt.phase),
    .sel      (sel_r),
    .buttons  (btn_r),
    .pins     (pins_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= '0;
      st_r.six_mode <= 1'b0;
      st_r.last_sel <= 1'b1;
      st_r.idle_cnt <= '0;
      out_valid_r   <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      pins_r     <= pins_nxt;
      six_mode_r <= st_nxt.six_mode;
      phase_r    <= st_nxt.phase;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pins      = pins_r;
  assign out_six_mode  = six_mode_r;
  assign out_phase_now = phase_r;

endmodule
